// ===== sv/stkil_pkg.sv =====
// ----------------------------------------------------------------------------
// stkil_pkg: shared types and constants of the sorted K-best candidate list
// Request kinds, slot entry layout, cell control bundle and field widths.
// ----------------------------------------------------------------------------
package stkil_pkg;

  // Default list depth (K)
  localparam int unsigned NUM_BEST_DEF = 5;

  // Fixed field widths
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IN_DW   = 72;
  localparam int unsigned OUT_DW  = 72;

  // Request kinds carried on in_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // One slot of the list
  typedef struct packed {
    logic                    valid;
    logic signed [OFS_W-1:0] ofs_x;
    logic signed [OFS_W-1:0] ofs_y;
    logic [ERR_W-1:0]        err;
  } entry_t;

  // Per-request control broadcast to every cell
  typedef struct packed {
    logic push;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== sv/stkil_cell.sv =====
// ----------------------------------------------------------------------------
// stkil_cell: one slot of the sorted candidate chain
// Compares the candidate against its own entry, then holds, takes the
// candidate, or takes the entry of the cell above on a shift; clear empties it.
// ----------------------------------------------------------------------------
module stkil_cell
  import stkil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     cand,
  input  entry_t     prev_entry,
  input  logic       prev_gt,
  output entry_t     entry,
  output logic       gt,
  output logic       take
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Slot is past the insertion point: empty or strictly worse than candidate
  assign gt    = !entry_r.valid || (entry_r.err > cand.err);
  assign take  = gt && !prev_gt;
  assign entry = entry_r;

  // Choose next contents: shift down, take candidate, or hold
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.clear) begin
      entry_nxt.valid = 1'b0;
    end else if (ctrl.push) begin
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt) begin
        entry_nxt       = cand;
        entry_nxt.valid = 1'b1;
      end
    end
  end

  // Slot register: reset empties the slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== sv/sorted_top_k_insert_list.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_insert_list: K-best candidate list sorted by rising error
// Chain of NUM_BEST slot cells with a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one request per accepted item. in_tuser selects
//   the kind: push a candidate, read the slot at read_index, or clear the
//   list. Every request yields exactly one result on the out_ channel.
//   A push places the candidate ahead of the first slot that is empty or
//   holds a strictly larger error; later slots move down one cell and the
//   last one falls off. A candidate no better than a full list is dropped.
//   Output: the result is registered, in the cycle after the request is
//   accepted. Throughput: one request per cycle while out_tready is high;
//   every cell compares against the candidate in parallel and loads from its
//   neighbor in the same edge. Stall: the result register holds while
//   out_tready is low, and in_tready follows it, so a new request enters
//   only when the result register is empty or its result leaves.
//   Reset: all slots become empty at once and no result is pending.
// ----------------------------------------------------------------------------
module sorted_top_k_insert_list
  import stkil_pkg::*;
#(
  parameter int unsigned NUM_BEST = NUM_BEST_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // in_tdata, low bit up: cand_offset_x[15:0], cand_offset_y[31:16],
  //   cand_error[63:32], read_index[69:64], zero fill[71:70]
  input  logic [IN_DW-1:0]  in_tdata,
  // in_tuser: mode[1:0]
  input  logic [MODE_W-1:0] in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_tdata, low bit up: out_offset_x[15:0], out_offset_y[31:16],
  //   out_error[63:32], out_valid[64], inserted[65], insert_position[71:66]
  output logic [OUT_DW-1:0] out_tdata
);

  logic             accept;
  cell_ctrl_t       ctrl;
  entry_t           cand;
  logic [POS_W-1:0] rd_idx;

  logic   gt_chain    [NUM_BEST+1];
  entry_t entry_chain [NUM_BEST+1];
  logic   take_vec    [NUM_BEST];

  logic [OUT_DW-1:0] res_nxt;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_valid_r;

  // Accept whenever the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Unpack request
  assign cand.valid = 1'b1;
  assign cand.ofs_x = in_tdata[15:0];
  assign cand.ofs_y = in_tdata[31:16];
  assign cand.err   = in_tdata[63:32];
  assign rd_idx     = in_tdata[69:64];

  assign ctrl.push  = accept && (in_tuser == MODE_PUSH);
  assign ctrl.clear = accept && (in_tuser == MODE_CLEAR);

  // Head of the chain: nothing above the first cell
  assign gt_chain[0]    = 1'b0;
  assign entry_chain[0] = '0;

  // Slot cells
  for (genvar i = 0; i < NUM_BEST; i++) begin : g_cell
    entry_t cell_entry;
    stkil_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cand       (cand),
      .prev_entry (entry_chain[i]),
      .prev_gt    (gt_chain[i]),
      .entry      (cell_entry),
      .gt         (gt_chain[i+1]),
      .take       (take_vec[i])
    );
    assign entry_chain[i+1] = cell_entry;
  end

  // Build result from the state before this request
  always_comb begin
    logic [POS_W-1:0] pos;
    entry_t           rd;
    pos     = '0;
    rd      = '0;
    res_nxt = '0;
    for (int i = 0; i < NUM_BEST; i++) begin
      if (take_vec[i]) begin
        pos = pos | POS_W'(i);
      end
      if (rd_idx == POS_W'(i) && entry_chain[i+1].valid) begin
        rd = rd | entry_chain[i+1];
      end
    end
    case (in_tuser)
      MODE_PUSH: begin
        if (gt_chain[NUM_BEST]) begin
          res_nxt[65]    = 1'b1;
          res_nxt[71:66] = pos;
        end
      end
      MODE_READ: begin
        res_nxt[15:0]  = rd.ofs_x;
        res_nxt[31:16] = rd.ofs_y;
        res_nxt[63:32] = rd.err;
        res_nxt[64]    = rd.valid;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Result handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/stkil_checker.sv =====
// ----------------------------------------------------------------------------
// stkil_checker: port-level checks of the sorted candidate list
// Watches result framing and field consistency on the top-level ports.
// ----------------------------------------------------------------------------
module stkil_checker
  import stkil_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_DW-1:0]  in_tdata,
  input logic [MODE_W-1:0] in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Drop any pending result at reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A result is either a read hit or an insertion, never both
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[64] && out_tdata[65]))
    else $error("read hit and insertion in one result");

  // Position is zero unless inserted
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[65] |-> out_tdata[71:66] == '0)
    else $error("insert position set without insertion");

  // Entry fields are zero unless the read hit
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[64] |-> out_tdata[63:0] == '0)
    else $error("entry fields set without read hit");

endmodule

bind sorted_top_k_insert_list stkil_checker u_stkil_checker (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted K-best candidate list
// Drives push, read, clear and unused requests over the in_ stream with
// random idle bursts on both sides. A scoreboard keeps its own copy of the
// sorted list and checks every result on the out_ stream field by field.
// ----------------------------------------------------------------------------
module testbench
  import stkil_pkg::*;
;

  localparam int unsigned NUM_BEST    = NUM_BEST_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RAND_ITEMS  = 1050;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_AT     = 300;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_CYCLES = 8;

  // Request payload, packed as on in_tdata (last field in the low bits)
  typedef struct packed {
    logic [1:0]              fill;
    logic [POS_W-1:0]        idx;
    logic [ERR_W-1:0]        err;
    logic signed [OFS_W-1:0] y;
    logic signed [OFS_W-1:0] x;
  } req_t;

  // Result payload, packed as on out_tdata
  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic                    inserted;
    logic                    valid;
    logic [ERR_W-1:0]        err;
    logic signed [OFS_W-1:0] y;
    logic signed [OFS_W-1:0] x;
  } result_t;

  // Shadow of the list plus the queue of results still owed by the block
  class best_list_tracker;
    entry_t  list_slots[NUM_BEST];
    result_t owed_results[$];
    int      fails;

    function new();
      empty_list();
      fails = 0;
    endfunction

    function void empty_list();
      for (int i = 0; i < NUM_BEST; i++) list_slots[i] = '0;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(logic [MODE_W-1:0] m, logic [IN_DW-1:0] d);
      req_t    q;
      result_t r;
      int      pos;
      q   = d;
      r   = '0;
      pos = -1;
      case (m)
        MODE_PUSH: begin
          // first slot that is empty or holds a strictly larger error
          for (int i = 0; i < NUM_BEST && pos < 0; i++) begin
            if (!list_slots[i].valid || list_slots[i].err > q.err) pos = i;
          end
          if (pos >= 0) begin
            for (int j = NUM_BEST - 1; j > pos; j--) list_slots[j] = list_slots[j-1];
            list_slots[pos].valid = 1'b1;
            list_slots[pos].ofs_x = q.x;
            list_slots[pos].ofs_y = q.y;
            list_slots[pos].err   = q.err;
            r.inserted = 1'b1;
            r.pos      = pos[POS_W-1:0];
          end
        end
        MODE_READ: begin
          if (q.idx < NUM_BEST && list_slots[q.idx].valid) begin
            r.x     = list_slots[q.idx].ofs_x;
            r.y     = list_slots[q.idx].ofs_y;
            r.err   = list_slots[q.idx].err;
            r.valid = 1'b1;
          end
        end
        MODE_CLEAR: empty_list();
        default: ;
      endcase
      owed_results.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] seen);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, seen);
      fails++;
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_result(logic [OUT_DW-1:0] d);
      result_t seen;
      result_t want;
      seen = d;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, d);
        fails++;
        return;
      end
      want = owed_results.pop_front();
      if (seen.x !== want.x) flag("out_offset_x", 32'(want.x), 32'(seen.x));
      if (seen.y !== want.y) flag("out_offset_y", 32'(want.y), 32'(seen.y));
      if (seen.err !== want.err) flag("out_error", want.err, seen.err);
      if (seen.valid !== want.valid) flag("out_valid", 32'(want.valid), 32'(seen.valid));
      if (seen.inserted !== want.inserted)
        flag("inserted", 32'(want.inserted), 32'(seen.inserted));
      if (seen.pos !== want.pos) flag("insert_position", 32'(want.pos), 32'(seen.pos));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [MODE_W-1:0] in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  bit quiet;
  bit long_hold_req;
  bit long_hold_done;

  best_list_tracker tracker = new();

  sorted_top_k_insert_list #(.NUM_BEST(NUM_BEST)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Watch both handshakes; results accepted at an edge belong to earlier requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (in_tvalid && in_tready) tracker.note_request(in_tuser, in_tdata);
    end
  end

  // Offer one request, with an optional idle burst first, and hold it until taken
  task automatic send_req(input logic [MODE_W-1:0] m, input req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_cand(input logic [15:0] x, input logic [15:0] y,
                           input logic [31:0] e);
    req_t r;
    r = '0;
    r.x = x;
    r.y = y;
    r.err = e;
    send_req(MODE_PUSH, r);
  endtask

  task automatic read_slot(input logic [POS_W-1:0] i);
    req_t r;
    r = '0;
    r.idx = i;
    send_req(MODE_READ, r);
  endtask

  // Result side: ready runs, short stalls and one long hold-off
  initial begin : sink
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Stimulus: directed corner cases, then random traffic, then drain
  initial begin : stimulus
    req_t             r;
    logic [MODE_W-1:0] m;
    int               roll;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_PUSH;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // read of an empty list
    read_slot(6'd0);
    // fill the list with extreme offsets and errors, ties included
    push_cand(16'h7fff, 16'h8000, 32'd100);
    push_cand(16'h8000, 16'h7fff, 32'd0);
    push_cand(16'hffff, 16'h0000, 32'd100);
    push_cand(16'h0000, 16'hffff, 32'hffff_ffff);
    push_cand(16'h1234, 16'hedcb, 32'd50);
    // full list: worst error is dropped, a better one evicts the tail
    push_cand(16'h5555, 16'haaaa, 32'hffff_ffff);
    push_cand(16'haaaa, 16'h5555, 32'd200);
    for (int i = 0; i < NUM_BEST; i++) read_slot(i[POS_W-1:0]);
    // index past the list
    read_slot(6'd5);
    read_slot(6'd63);
    // unused mode with every bit but the zero fill set leaves the list alone
    r = '1;
    r.fill = '0;
    send_req(MODE_UNUSED, r);
    read_slot(6'd1);
    // clear, then an empty slot takes even the worst error
    send_req(MODE_CLEAR, '0);
    read_slot(6'd0);
    push_cand(16'h0001, 16'h8001, 32'hffff_ffff);
    read_slot(6'd0);
    read_slot(6'd1);

    // random traffic: mostly pushes with clustered errors so ties happen
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == HOLD_AT) long_hold_req = 1'b1;
      if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      roll   = $urandom_range(0, 99);
      r      = '0;
      r.x    = OFS_W'($urandom());
      r.y    = OFS_W'($urandom());
      r.err  = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom();
      r.idx  = POS_W'($urandom_range(0, 3) != 0 ? $urandom_range(0, NUM_BEST) : $urandom());
      if (roll < 55) m = MODE_PUSH;
      else if (roll < 92) m = MODE_READ;
      else if (roll < 96) m = MODE_CLEAR;
      else m = MODE_UNUSED;
      send_req(m, r);
    end
    in_tvalid <= 1'b0;

    // drain owed results, then let any stray output show up
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("PASS sorted_top_k_insert_list");
    end else begin
      $display("FAIL sorted_top_k_insert_list");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4000000;
    $display("FAIL sorted_top_k_insert_list");
    $finish;
  end

endmodule
